[sv/lszl_pkg.sv]
// Shared types and register indexes for the line sensor zone locator.
package lszl_pkg;

	localparam int unsigned ReadingWidth = 8;
	localparam int unsigned ZoneWidth = 3;
	localparam int unsigned ChannelWidth = 2;
	localparam int unsigned CountWidth = 4;
	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth = 8;

	localparam logic [CountWidth-1:0] CountMax = 4'd15;

	// Configuration register indexes.
	typedef enum logic [CfgIndexWidth-1:0] {
		REG_TRANSIT_HORIZ_LEFT  = 3'd0,
		REG_TRANSIT_MID_LEFT    = 3'd1,
		REG_TRANSIT_MID_RIGHT   = 3'd2,
		REG_TRANSIT_HORIZ_RIGHT = 3'd3,
		REG_LOSS_THRESHOLD      = 3'd4,
		REG_SWITCH_MARGIN       = 3'd5,
		REG_JUMP_CONFIRM        = 3'd6,
		REG_UNUSED              = 3'd7
	} reg_index_t;

	// Sensor channel codes.
	typedef enum logic [ChannelWidth-1:0] {
		CH_MID_LEFT    = 2'd0,
		CH_MID_RIGHT   = 2'd1,
		CH_HORIZ_LEFT  = 2'd2,
		CH_HORIZ_RIGHT = 2'd3
	} channel_t;

	typedef struct packed {
		logic [ReadingWidth-1:0] transit_horiz_left;
		logic [ReadingWidth-1:0] transit_mid_left;
		logic [ReadingWidth-1:0] transit_mid_right;
		logic [ReadingWidth-1:0] transit_horiz_right;
		logic [ReadingWidth-1:0] loss_threshold;
		logic [ReadingWidth-1:0] switch_margin;
		logic [CountWidth-1:0]   jump_confirm;
	} cfg_t;

	typedef struct packed {
		logic [ReadingWidth-1:0] mid_left;
		logic [ReadingWidth-1:0] mid_right;
		logic [ReadingWidth-1:0] horiz_left;
		logic [ReadingWidth-1:0] horiz_right;
	} item_t;

	typedef struct packed {
		channel_t               strongest_now;
		channel_t               strongest_good;
		logic [ZoneWidth-1:0]   last_zone;
		logic [CountWidth-1:0]  jump_count;
	} track_t;

	typedef struct packed {
		logic [ZoneWidth-1:0] zone;
		channel_t             strongest_channel;
		logic                 signal_weak;
		logic                 jump_held;
	} result_t;

endpackage

[sv/lszl_cfg.sv]
// Configuration register file for the line sensor zone locator.
module lszl_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lszl_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [lszl_pkg::CfgDataWidth-1:0]   cfg_wdata,
	output lszl_pkg::cfg_t                      cfg
);

	lszl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transit_horiz_left  <= 8'd50;
			cfg_q.transit_mid_left    <= 8'd50;
			cfg_q.transit_mid_right   <= 8'd50;
			cfg_q.transit_horiz_right <= 8'd50;
			cfg_q.loss_threshold      <= 8'd40;
			cfg_q.switch_margin       <= 8'd2;
			cfg_q.jump_confirm        <= 4'd3;
		end else if (cfg_we) begin
			unique case (lszl_pkg::reg_index_t'(cfg_index))
				lszl_pkg::REG_TRANSIT_HORIZ_LEFT:  cfg_q.transit_horiz_left  <= cfg_wdata;
				lszl_pkg::REG_TRANSIT_MID_LEFT:    cfg_q.transit_mid_left    <= cfg_wdata;
				lszl_pkg::REG_TRANSIT_MID_RIGHT:   cfg_q.transit_mid_right   <= cfg_wdata;
				lszl_pkg::REG_TRANSIT_HORIZ_RIGHT: cfg_q.transit_horiz_right <= cfg_wdata;
				lszl_pkg::REG_LOSS_THRESHOLD:      cfg_q.loss_threshold      <= cfg_wdata;
				lszl_pkg::REG_SWITCH_MARGIN:       cfg_q.switch_margin       <= cfg_wdata;
				lszl_pkg::REG_JUMP_CONFIRM:
					cfg_q.jump_confirm <= cfg_wdata[lszl_pkg::CountWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/lszl_core.sv]
// Combinational channel tracking, zone pick and jump filter for one item.
module lszl_core (
	input  lszl_pkg::item_t   item,
	input  lszl_pkg::track_t  track,
	input  lszl_pkg::cfg_t    cfg,
	output lszl_pkg::result_t result,
	output lszl_pkg::track_t  track_next
);

	logic [lszl_pkg::ReadingWidth-1:0] val [4];

	assign val[0] = item.mid_left;
	assign val[1] = item.mid_right;
	assign val[2] = item.horiz_left;
	assign val[3] = item.horiz_right;

	always_comb begin
		logic [lszl_pkg::ChannelWidth-1:0] cur;
		logic [lszl_pkg::ReadingWidth:0]   bar;
		logic [lszl_pkg::ZoneWidth-1:0]    zone;
		logic [lszl_pkg::ZoneWidth-1:0]    diff;
		logic [lszl_pkg::CountWidth-1:0]   cnt;
		logic                              low_signal;

		// Scan in channel order; each step compares against the running pick.
		cur = track.strongest_now;
		for (int i = 0; i < 4; i++) begin
			bar = {1'b0, val[cur]} + {1'b0, cfg.switch_margin};
			if ({1'b0, val[i]} > bar) begin
				cur = lszl_pkg::ChannelWidth'(i);
			end
		end

		track_next = track;
		low_signal = (val[cur] < cfg.loss_threshold);
		if (low_signal) begin
			cur = track.strongest_good;
		end else begin
			track_next.strongest_good = lszl_pkg::channel_t'(cur);
		end
		track_next.strongest_now = lszl_pkg::channel_t'(cur);

		case (lszl_pkg::channel_t'(cur))
			lszl_pkg::CH_HORIZ_LEFT:
				zone = (item.mid_left < cfg.transit_horiz_left) ? 3'd0 : 3'd1;
			lszl_pkg::CH_MID_LEFT:
				zone = (item.mid_right < cfg.transit_mid_left) ? 3'd1 : 3'd2;
			lszl_pkg::CH_MID_RIGHT:
				zone = (item.mid_left < cfg.transit_mid_right) ? 3'd3 : 3'd2;
			default:
				zone = (item.mid_right < cfg.transit_horiz_right) ? 3'd4 : 3'd3;
		endcase

		diff = (zone > track.last_zone) ? zone - track.last_zone : track.last_zone - zone;
		cnt = (track.jump_count < lszl_pkg::CountMax) ? track.jump_count + 4'd1
			: track.jump_count;
		result.jump_held = 1'b0;
		if (diff >= 3'd2) begin
			if (cnt > cfg.jump_confirm) begin
				track_next.last_zone  = zone;
				track_next.jump_count = '0;
			end else begin
				track_next.jump_count = cnt;
				zone = track.last_zone;
				result.jump_held = 1'b1;
			end
		end else begin
			track_next.last_zone  = zone;
			track_next.jump_count = '0;
		end

		result.zone = zone;
		result.strongest_channel = lszl_pkg::channel_t'(cur);
		result.signal_weak = low_signal;
	end

endmodule

[sv/line_sensor_zone_locator.sv]
// Top level of the line sensor zone locator: item registers, tracking state and result register.
//
// The block takes one item of four normalized inductor readings and gives one result item
// with the filtered zone, the channel in use, a weak-signal flag and a jump-held flag.
// An item is captured in an input register, worked out by combinational compare logic
// against the tracking state, and written to the result register together with the state
// update, so one item goes in and one result comes out every cycle while out_ready does not
// hold back a full result register. The result is valid once the item has moved from the
// input register into the result register. Each of the two registers holds one item, so a new
// item is still accepted into an empty input register while a finished result waits.
// Configuration registers are written through a plain write port and should only be
// changed while no item is in flight.
module line_sensor_zone_locator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lszl_pkg::ReadingWidth-1:0]   mid_left,
	input  logic [lszl_pkg::ReadingWidth-1:0]   mid_right,
	input  logic [lszl_pkg::ReadingWidth-1:0]   horiz_left,
	input  logic [lszl_pkg::ReadingWidth-1:0]   horiz_right,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lszl_pkg::ZoneWidth-1:0]      zone,
	output logic [lszl_pkg::ChannelWidth-1:0]   strongest_channel,
	output logic                                signal_weak,
	output logic                                jump_held,
	input  logic                                cfg_we,
	input  logic [lszl_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [lszl_pkg::CfgDataWidth-1:0]   cfg_wdata
);

	lszl_pkg::cfg_t    cfg;
	lszl_pkg::item_t   item_s1;
	logic              valid_s1;
	lszl_pkg::track_t  track_q;
	lszl_pkg::track_t  track_next;
	lszl_pkg::result_t result;
	lszl_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;
	logic              step;

	lszl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The result register moves when it is empty or its item is being taken.
	assign advance  = !valid_s2 || out_ready;
	assign step     = advance && valid_s1;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mid_left    <= mid_left;
			item_s1.mid_right   <= mid_right;
			item_s1.horiz_left  <= horiz_left;
			item_s1.horiz_right <= horiz_right;
		end
	end

	lszl_core u_core (
		.item       (item_s1),
		.track      (track_q),
		.cfg        (cfg),
		.result     (result),
		.track_next (track_next)
	);

	// Tracking state only moves when an item is handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (step) begin
			track_q <= track_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid         = valid_s2;
	assign zone              = result_s2.zone;
	assign strongest_channel = result_s2.strongest_channel;
	assign signal_weak       = result_s2.signal_weak;
	assign jump_held         = result_s2.jump_held;

	// A delivered zone is always one of the five zones.
	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.zone <= 3'd4))
		else $error("zone out of range");

	// A held jump leaves the accepted zone untouched.
	a_held_keeps_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.jump_held) |=> (track_q.last_zone == $past(track_q.last_zone)))
		else $error("held jump changed last zone");

	// A weak item does not replace the last good channel.
	a_weak_keeps_good: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.signal_weak) |=>
			(track_q.strongest_good == $past(track_q.strongest_good)))
		else $error("weak item changed good channel");

	// Taking the last result with nothing behind it empties the result register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_ready && !valid_s1) |=> !valid_s2)
		else $error("result repeated");

endmodule
